// ===== design/dual_channel_dds_sample_generator_assert.svh =====
// Assertion macros for the sample generator.
// Each macro takes a label, a clock, an active-low reset, a trigger and a consequence.
`ifndef DUAL_CHANNEL_DDS_SAMPLE_GENERATOR_ASSERT_SVH
`define DUAL_CHANNEL_DDS_SAMPLE_GENERATOR_ASSERT_SVH

`ifndef SYNTH

// Consequence holds in the same cycle as the trigger.
`define DCDDS_ASSERT_SAME(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("dcdds assertion failed (same cycle)");

// Consequence holds in the cycle after the trigger.
`define DCDDS_ASSERT_NEXT(label, clk, rst_n, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("dcdds assertion failed (next cycle)");

`else

`define DCDDS_ASSERT_SAME(label, clk, rst_n, trig, cons)
`define DCDDS_ASSERT_NEXT(label, clk, rst_n, trig, cons)

`endif

`endif

// ===== design/dcdds_pkg.sv =====
package dcdds_pkg;

    localparam int SAMPLE_W    = 8;
    localparam int PHASE_W     = 32;
    localparam int GAIN_W      = 9;
    localparam int PEND_W      = 9;
    localparam int STRETCH_W   = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_A_W     = STRETCH_W + 1;
    localparam int STRETCH_SH  = 16;
    localparam int GAIN_SH     = 8;
    localparam int SCALED_W    = 12;

    localparam logic [SAMPLE_W-1:0] MIDSCALE   = 8'd128;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PHASE_INC   = 3'd0,
        CFG_PHASE_OFF   = 3'd1,
        CFG_GAIN        = 3'd2,
        CFG_PWM_MODE    = 3'd3,
        CFG_QUARTER     = 3'd4,
        CFG_PULSE_END   = 3'd5,
        CFG_STRETCH     = 3'd6,
        CFG_PAUSED      = 3'd7
    } cfg_reg_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_READ,
        ST_SCALE,
        ST_CLAMP,
        ST_DONE
    } state_t;

    // Control from the sequencer's output decode
    typedef struct packed {
        logic mul_en;
        logic mul_gain;
        logic rd_en;
        logic idx_load;
        logic samp_load;
        logic chan_next;
        logic out_load;
    } ctrl_t;

endpackage

// ===== design/dcdds_mul.sv =====
module dcdds_mul
    import dcdds_pkg::*;
#(
    parameter int B_W = 13
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [MUL_A_W-1:0]        a,
    input  logic signed [B_W-1:0]            b,
    output logic signed [MUL_A_W+B_W-1:0]    product
);

    logic signed [MUL_A_W+B_W-1:0] product_reg;

    // Registered signed multiply, shared by the index stretch and the gain stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= (MUL_A_W+B_W)'(a) * (MUL_A_W+B_W)'(b);
        end
    end

    assign product = product_reg;

endmodule

// ===== design/dual_channel_dds_sample_generator.sv =====
// Two-channel DDS sample generator. A tick transaction (operation 0) yields one
// result holding an 8-bit sample for each channel and then, unless paused,
// advances the 32-bit phase accumulator by phase_increment; channel two reads
// the wave table at the phase plus channel_phase_offset. Samples are scaled
// about midscale by a Q8 gain and clamped to 0..255. With pwm_mode set, table
// indices at or past pulse_end_index give zero, the rest are stretched by a Q16
// factor, clamped and optionally moved back a quarter table. A write
// transaction (operation 1) loads one table entry and yields no result; read
// only entries written before. A write transaction leaves the block idle; a
// running tick steps through index, read, scale and clamp for each channel and
// then loads the output register, a paused tick loads midscale into it directly.
// The sequence is set by the single shared multiplier, used twice per channel,
// and the single registered read port of the wave table. in_stall is high
// while a tick is in progress; the finished result waits in an output register,
// so a new transaction is taken while it is still stalled downstream.
module dual_channel_dds_sample_generator
    import dcdds_pkg::*;
#(
    parameter int TABLE_SIZE = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_write,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    operation,
    input  logic [7:0]              table_address,
    input  logic [7:0]              table_data,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_W-1:0]     first_sample,
    output logic [SAMPLE_W-1:0]     second_sample
);

    `include "dual_channel_dds_sample_generator_assert.svh"

    // Address width of the table, and index bits taken from the phase (floor log2)
    localparam int AW     = $clog2(TABLE_SIZE);
    localparam int IB     = $clog2(TABLE_SIZE + 1) - 1;
    localparam int MUL_B_W = ((IB > GAIN_W) ? IB : GAIN_W) + 1;
    localparam int PROD_W = MUL_A_W + MUL_B_W;
    localparam int SRC_W  = PROD_W - STRETCH_SH;
    localparam int Q_OFF  = TABLE_SIZE - TABLE_SIZE / 4;

    // Configuration registers
    logic [PHASE_W-1:0]   phase_inc_reg;
    logic [PHASE_W-1:0]   phase_off_reg;
    logic [GAIN_W-1:0]    gain_reg;
    logic                 pwm_reg;
    logic                 quarter_reg;
    logic [PEND_W-1:0]    pulse_end_reg;
    logic [STRETCH_W-1:0] stretch_reg;
    logic                 paused_reg;

    // Sequencer and datapath state
    state_t               state_reg;
    state_t               state_next;
    ctrl_t                ctrl;
    logic [PHASE_W-1:0]   acc_reg;
    logic                 chan_reg;
    logic                 hold_reg;
    logic [IB-1:0]        idx_reg;
    logic                 zero_reg;
    logic [SAMPLE_W-1:0]  samp0_reg;
    logic [SAMPLE_W-1:0]  samp1_reg;
    logic                 out_valid_reg;
    logic [SAMPLE_W-1:0]  first_reg;
    logic [SAMPLE_W-1:0]  second_reg;

    // Wave table
    logic [SAMPLE_W-1:0]  table_mem [TABLE_SIZE];
    logic [SAMPLE_W-1:0]  rdata_reg;

    logic                 in_accept;
    logic                 tick_accept;
    logic                 write_accept;
    logic                 out_free;

    logic [PHASE_W-1:0]   phase_sel;
    logic [IB-1:0]        idx;
    logic                 off_window;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  product;

    logic [SRC_W-1:0]     src_full;
    logic [AW-1:0]        src_clamped;
    logic [AW:0]          src_sum;
    logic [AW-1:0]        src_shifted;
    logic [AW-1:0]        rd_addr;

    logic [SAMPLE_W-1:0]  raw;
    logic signed [GAIN_W-1:0]   raw_diff;
    logic signed [SCALED_W-1:0] scaled;
    logic [SAMPLE_W-1:0]  clamped;

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign in_stall     = (state_reg != ST_IDLE);
    assign in_accept    = in_valid && !in_stall;
    assign tick_accept  = in_accept && (operation == OP_TICK);
    assign write_accept = in_accept && (operation == OP_WRITE);
    assign out_free     = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign first_sample  = first_reg;
    assign second_sample = second_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_inc_reg <= PHASE_W'(1);
            phase_off_reg <= '0;
            gain_reg      <= GAIN_W'(256);
            pwm_reg       <= 1'b0;
            quarter_reg   <= 1'b0;
            pulse_end_reg <= '0;
            stretch_reg   <= '0;
            paused_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_PHASE_INC: phase_inc_reg <= cfg_data;
                CFG_PHASE_OFF: phase_off_reg <= cfg_data;
                CFG_GAIN:      gain_reg      <= cfg_data[GAIN_W-1:0];
                CFG_PWM_MODE:  pwm_reg       <= cfg_data[0];
                CFG_QUARTER:   quarter_reg   <= cfg_data[0];
                CFG_PULSE_END: pulse_end_reg <= cfg_data[PEND_W-1:0];
                CFG_STRETCH:   stretch_reg   <= cfg_data[STRETCH_W-1:0];
                CFG_PAUSED:    paused_reg    <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = paused_reg ? ST_DONE : ST_INDEX;
                end
            end
            ST_INDEX: state_next = ST_READ;
            ST_READ:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_CLAMP;
            ST_CLAMP: state_next = chan_reg ? ST_DONE : ST_INDEX;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control decode
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ST_INDEX:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.idx_load = 1'b1;
            end
            ST_READ:
            begin
                ctrl.rd_en = 1'b1;
            end
            ST_SCALE:
            begin
                ctrl.mul_en   = 1'b1;
                ctrl.mul_gain = 1'b1;
            end
            ST_CLAMP:
            begin
                ctrl.samp_load = 1'b1;
                ctrl.chan_next = 1'b1;
            end
            ST_DONE:
            begin
                ctrl.out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Index generation: phase for the current channel, PWM window test
    // ------------------------------------------------------------------
    assign phase_sel = chan_reg ? (acc_reg + phase_off_reg) : acc_reg;
    assign idx       = phase_sel[PHASE_W-1 -: IB];
    assign off_window = pwm_reg &&
                        ((pulse_end_reg == '0) || (32'(idx) >= 32'(pulse_end_reg)));

    // ------------------------------------------------------------------
    // Shared multiplier operands: stretch in the index step, gain in the scale step
    // ------------------------------------------------------------------
    assign raw      = zero_reg ? '0 : rdata_reg;
    assign raw_diff = signed'({1'b0, raw}) - signed'(GAIN_W'(MIDSCALE));

    always_comb
    begin
        if (ctrl.mul_gain)
        begin
            mul_a = MUL_A_W'(raw_diff);
            mul_b = signed'({{(MUL_B_W-GAIN_W){1'b0}}, gain_reg});
        end
        else
        begin
            mul_a = signed'({1'b0, stretch_reg});
            mul_b = signed'({{(MUL_B_W-IB){1'b0}}, idx});
        end
    end

    dcdds_mul #(
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .en      (ctrl.mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (product)
    );

    // ------------------------------------------------------------------
    // Table address: clamp the stretched index, then wrap the quarter shift
    // ------------------------------------------------------------------
    assign src_full    = product[PROD_W-1:STRETCH_SH];
    assign src_clamped = (src_full >= SRC_W'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1)
                                                           : src_full[AW-1:0];
    assign src_sum     = (AW+1)'(src_clamped) + (AW+1)'(Q_OFF);
    assign src_shifted = (src_sum >= (AW+1)'(TABLE_SIZE))
                         ? AW'(src_sum - (AW+1)'(TABLE_SIZE))
                         : src_sum[AW-1:0];

    always_comb
    begin
        if (!pwm_reg)
        begin
            rd_addr = AW'(idx_reg);
        end
        else if (quarter_reg)
        begin
            rd_addr = src_shifted;
        end
        else
        begin
            rd_addr = src_clamped;
        end
    end

    // Table write on a write transaction, registered read in the read step
    always_ff @(posedge clk)
    begin
        if (write_accept && (32'(table_address) < 32'(TABLE_SIZE)))
        begin
            table_mem[AW'(table_address)] <= table_data;
        end
        if (ctrl.rd_en)
        begin
            rdata_reg <= table_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Gain result: floor shift by 8 about midscale, clamp to 0..255
    // ------------------------------------------------------------------
    assign scaled = SCALED_W'(MIDSCALE) + signed'(product[GAIN_SH +: SCALED_W]);

    always_comb
    begin
        if (scaled < 0)
        begin
            clamped = '0;
        end
        else if (scaled > SCALED_W'(FULL_SCALE))
        begin
            clamped = FULL_SCALE;
        end
        else
        begin
            clamped = scaled[SAMPLE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            chan_reg      <= 1'b0;
            hold_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick_accept)
            begin
                chan_reg <= 1'b0;
                hold_reg <= paused_reg;
            end
            else if (ctrl.chan_next)
            begin
                chan_reg <= 1'b1;
            end

            // Advance the phase only once the pair is handed to the output register
            if (ctrl.out_load && !hold_reg)
            begin
                acc_reg <= acc_reg + phase_inc_reg;
            end

            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.idx_load)
        begin
            idx_reg  <= idx;
            zero_reg <= off_window;
        end
        if (tick_accept)
        begin
            samp0_reg <= MIDSCALE;
            samp1_reg <= MIDSCALE;
        end
        else if (ctrl.samp_load)
        begin
            if (chan_reg)
            begin
                samp1_reg <= clamped;
            end
            else
            begin
                samp0_reg <= clamped;
            end
        end
        if (ctrl.out_load)
        begin
            first_reg  <= samp0_reg;
            second_reg <= samp1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DCDDS_ASSERT_NEXT(a_tick_busy, clk, rst_n, tick_accept, state_reg != ST_IDLE)
    `DCDDS_ASSERT_NEXT(a_acc_hold, clk, rst_n, !ctrl.out_load, $stable(acc_reg))
    `DCDDS_ASSERT_NEXT(a_result_shown, clk, rst_n, ctrl.out_load, out_valid_reg)
    `DCDDS_ASSERT_SAME(a_chan_order, clk, rst_n, state_reg == ST_DONE && !hold_reg, chan_reg)

endmodule

// ===== tb/dual_channel_dds_sample_generator_tb.sv =====
`timescale 1ns / 100ps

module dual_channel_dds_sample_generator_tb;
    import dcdds_pkg::*;

    // Table depth and index width as built into the block
    localparam int TBL_SIZE       = 256;
    localparam int TBL_IDX_W      = 8;
    // Cycles to let pass once the block has gone quiet
    localparam int SETTLE_CYCLES  = 16;
    // Long receiver hold-off that fills the block and backs up its input
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 22;

    typedef struct packed {
        op_t        op;
        logic [7:0] addr;
        logic [7:0] data;
    } table_item_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] first;
        logic [SAMPLE_W-1:0] second;
    } sample_pair_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;

    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  operation = 1'b0;
    logic [7:0]            table_address = '0;
    logic [7:0]            table_data = '0;

    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [SAMPLE_W-1:0]   first_sample;
    logic [SAMPLE_W-1:0]   second_sample;

    // Predictor state: phase, wave table and a copy of every register
    logic [PHASE_W-1:0]    phase_acc = '0;
    logic [7:0]            wave_mem [TBL_SIZE];
    logic [PHASE_W-1:0]    m_phase_inc = 32'd1;
    logic [PHASE_W-1:0]    m_phase_off = '0;
    logic [GAIN_W-1:0]     m_gain = 9'd256;
    logic                  m_pwm_mode = 1'b0;
    logic                  m_quarter = 1'b0;
    logic [PEND_W-1:0]     m_pulse_end = '0;
    logic [STRETCH_W-1:0]  m_stretch = '0;
    logic                  m_paused = 1'b1;

    table_item_t           pending_items [$];
    sample_pair_t          expected_pairs [$];

    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    bit                    holdoff_armed = 1'b0;
    int                    holdoff_count = 0;
    int                    fail_count = 0;

    dual_channel_dds_sample_generator #(
        .TABLE_SIZE(TBL_SIZE)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .table_address (table_address),
        .table_data    (table_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .first_sample  (first_sample),
        .second_sample (second_sample)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Raw table value for one channel's phase, with the PWM window applied
    function automatic logic [7:0] wave_lookup(logic [PHASE_W-1:0] phase);
        logic [TBL_IDX_W-1:0] idx;
        logic [63:0]          src;
        idx = phase[PHASE_W-1 -: TBL_IDX_W];
        if (!m_pwm_mode)
            return wave_mem[idx];
        // Past the pulse end, or no pulse at all: output is off
        if (m_pulse_end == '0 || PEND_W'(idx) >= m_pulse_end)
            return 8'd0;
        // Stretch at full width, then pin to the last entry rather than wrap
        src = (64'(idx) * 64'(m_stretch)) >> STRETCH_SH;
        if (src > 64'(TBL_SIZE - 1))
            src = 64'(TBL_SIZE - 1);
        if (m_quarter)
            src = (src + 64'(TBL_SIZE - TBL_SIZE / 4)) % 64'(TBL_SIZE);
        return wave_mem[src[TBL_IDX_W-1:0]];
    endfunction

    // Scale about midscale; the arithmetic shift floors negative products
    function automatic logic [SAMPLE_W-1:0] apply_gain(logic [7:0] raw);
        int prod;
        int level;
        prod  = (int'(raw) - int'(MIDSCALE)) * int'(m_gain);
        level = int'(MIDSCALE) + (prod >>> GAIN_SH);
        if (level < 0)
            return '0;
        if (level > int'(FULL_SCALE))
            return FULL_SCALE;
        return level[SAMPLE_W-1:0];
    endfunction

    // Sample pair for one tick; advance the phase unless paused
    function automatic sample_pair_t synth_sample_pair();
        sample_pair_t pair;
        if (m_paused)
        begin
            pair.first  = MIDSCALE;
            pair.second = MIDSCALE;
            return pair;
        end
        pair.first  = apply_gain(wave_lookup(phase_acc));
        pair.second = apply_gain(wave_lookup(phase_acc + m_phase_off));
        phase_acc   = phase_acc + m_phase_inc;
        return pair;
    endfunction

    // Driver: hold a stalled transaction, otherwise offer the next one or idle
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        table_item_t next_item;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            // Predict from the payload that was on the ports at this edge
            if (in_valid && !in_stall)
            begin
                if (op_t'(operation) == OP_WRITE)
                    wave_mem[table_address] = table_data;
                else
                    expected_pairs.push_back(synth_sample_pair());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_item      = pending_items.pop_front();
                    in_valid      <= 1'b1;
                    operation     <= next_item.op;
                    table_address <= next_item.addr;
                    table_data    <= next_item.data;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Count out the long hold-off once it is armed
    always @(posedge clk)
    begin : holdoff_proc
        if (holdoff_armed && holdoff_count < HOLDOFF_CYCLES)
        begin
            holdoff_count <= holdoff_count + 1;
        end
    end

    // Monitor: check each accepted result against the oldest prediction,
    // then decide the stall for the next cycle
    always @(posedge clk or negedge rst_n)
    begin : result_proc
        sample_pair_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $error("result %0d/%0d with no prediction pending",
                           first_sample, second_sample);
                    fail_count++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (first_sample !== want.first)
                    begin
                        $error("first_sample: expected %0d, got %0d", want.first, first_sample);
                        fail_count++;
                    end
                    if (second_sample !== want.second)
                    begin
                        $error("second_sample: expected %0d, got %0d",
                               want.second, second_sample);
                        fail_count++;
                    end
                end
            end
            // Once armed, stall solidly for the whole hold-off, then go back to random
            if (holdoff_armed && holdoff_count < HOLDOFF_CYCLES)
            begin
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    // Write one register and update the predictor's copy; the block is idle
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PHASE_INC: m_phase_inc = value;
            CFG_PHASE_OFF: m_phase_off = value;
            CFG_GAIN:      m_gain      = value[GAIN_W-1:0];
            CFG_PWM_MODE:  m_pwm_mode  = value[0];
            CFG_QUARTER:   m_quarter   = value[0];
            CFG_PULSE_END: m_pulse_end = value[PEND_W-1:0];
            CFG_STRETCH:   m_stretch   = value[STRETCH_W-1:0];
            CFG_PAUSED:    m_paused    = value[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic program_setup(logic [31:0] inc, logic [31:0] off, int gain,
                                 bit pwm, bit quarter, int pulse_end, int stretch,
                                 bit pause);
        write_reg(CFG_PHASE_INC, inc);
        write_reg(CFG_PHASE_OFF, off);
        write_reg(CFG_GAIN,      32'(gain));
        write_reg(CFG_PWM_MODE,  32'(pwm));
        write_reg(CFG_QUARTER,   32'(quarter));
        write_reg(CFG_PULSE_END, 32'(pulse_end));
        write_reg(CFG_STRETCH,   32'(stretch));
        write_reg(CFG_PAUSED,    32'(pause));
    endtask

    // Random setting, weighted towards the edges of each register's range
    task automatic program_random_setup();
        logic [31:0] inc;
        logic [31:0] off;
        int          gain;
        int          pulse_end;
        int          stretch;
        case ($urandom_range(0, 4))
            0:       inc = 32'd1;
            1:       inc = 32'hFFFF_FFFF;
            2:       inc = $urandom_range(1, 32'h0400_0000);
            default: inc = $urandom;
        endcase
        if (inc == '0)
            inc = 32'd1;
        case ($urandom_range(0, 3))
            0:       off = '0;
            1:       off = 32'hFFFF_FFFF;
            default: off = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       gain = 0;
            1:       gain = 256;
            2:       gain = $urandom_range(257, 511);
            default: gain = $urandom_range(0, 256);
        endcase
        case ($urandom_range(0, 3))
            0:       pulse_end = 0;
            1:       pulse_end = 256;
            default: pulse_end = $urandom_range(1, 256);
        endcase
        case ($urandom_range(0, 4))
            0:       stretch = 0;
            1:       stretch = 1 << 24;
            2:       stretch = 1 << 16;
            3:       stretch = $urandom_range(0, 1 << 20);
            default: stretch = $urandom_range(0, 1 << 24);
        endcase
        program_setup(inc, off, gain, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      pulse_end, stretch, $urandom_range(0, 7) == 0);
    endtask

    task automatic queue_item(op_t op, logic [7:0] addr, logic [7:0] data);
        table_item_t item;
        item.op   = op;
        item.addr = addr;
        item.data = data;
        pending_items.push_back(item);
    endtask

    task automatic queue_ticks(int count);
        repeat (count) queue_item(OP_TICK, 8'($urandom), 8'($urandom));
    endtask

    // Mostly ticks, with table rewrites mixed in; the table is fully loaded
    // by then, so no read ever lands on an unwritten entry
    task automatic queue_random_items(int count);
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 15)
                queue_item(OP_WRITE, 8'($urandom), 8'($urandom));
            else
                queue_item(OP_TICK, 8'($urandom), 8'($urandom));
        end
    endtask

    // Wait for the block to go quiet: nothing queued, nothing offered,
    // nothing predicted; then let a write still in flight settle
    task automatic wait_quiet();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || in_valid || expected_pairs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Paused after reset: ticks give midscale and read no table entry
        queue_ticks(2);
        // Load the whole table, pinning the corners of the data range
        for (int a = 0; a < TBL_SIZE; a++)
        begin
            case (a)
                0:       queue_item(OP_WRITE, 8'(a), 8'h00);
                1:       queue_item(OP_WRITE, 8'(a), 8'hFF);
                TBL_SIZE - 1: queue_item(OP_WRITE, 8'(a), 8'hFF);
                128:     queue_item(OP_WRITE, 8'(a), MIDSCALE);
                default: queue_item(OP_WRITE, 8'(a), 8'($urandom));
            endcase
        end
        wait_quiet();

        // Plain readout, one entry per tick, channel two offset by half the table
        program_setup(32'h0100_0000, 32'h8000_0000, 256, 0, 0, 0, 0, 0);
        queue_ticks(4);
        wait_quiet();

        // Largest step and offset with zero gain: everything collapses to midscale
        program_setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0);
        queue_ticks(3);
        wait_quiet();

        // Gain above unity on the smallest step: clamps at both rails
        program_setup(32'd1, 32'h0100_0000, 511, 0, 0, 0, 0, 0);
        queue_ticks(2);
        wait_quiet();

        // PWM with no pulse: always off
        program_setup(32'h0100_0000, 32'h4000_0000, 256, 1, 0, 0, 1 << 16, 0);
        queue_ticks(2);
        wait_quiet();

        // Widest pulse with a stretch of 256: index pinned, then moved back
        // a quarter table with wrap
        program_setup(32'h0100_0000, 32'h0000_0000, 256, 1, 1, 256, 1 << 24, 0);
        queue_ticks(4);
        wait_quiet();

        // Short pulse stretched by sixteen, stepping across the pulse end
        program_setup(32'h0600_0000, 32'h0300_0000, 200, 1, 0, 16, 1 << 20, 0);
        queue_ticks(4);
        wait_quiet();

        // Pause mid-run: phase holds, then carries on from where it stopped
        program_setup(32'h0500_0000, 32'h0123_4567, 256, 0, 0, 0, 0, 1);
        queue_ticks(2);
        wait_quiet();
        write_reg(CFG_PAUSED, 32'd0);
        queue_ticks(2);
        wait_quiet();

        // Random phases, cycling through the idling patterns
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            program_random_setup();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            // One phase runs the long hold-off while the sender keeps offering
            if (p == 4)
                holdoff_armed = 1'b1;
            queue_random_items(PHASE_ITEMS);
            wait_quiet();
        end

        if (expected_pairs.size() != 0)
        begin
            $error("%0d predicted results never arrived", expected_pairs.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("dual_channel_dds_sample_generator_tb: PASS");
        else
            $display("dual_channel_dds_sample_generator_tb: FAIL");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here
    initial
    begin
        #5_000_000;
        $display("dual_channel_dds_sample_generator_tb: FAIL");
        $finish;
    end

endmodule
